// File: rtl/complex_halfband_decimator_q15_macros.svh
// Assertion macros for the complex halfband decimator.
// Included by the top level; depends on nothing else.
`ifndef COMPLEX_HALFBAND_DECIMATOR_Q15_MACROS_SVH
`define COMPLEX_HALFBAND_DECIMATOR_Q15_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CHBD_ASSERT_SAME(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("chbd: same-cycle check failed");
`define CHBD_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("chbd: next-cycle check failed");
`else
`define CHBD_ASSERT_SAME(label, clk, rst_n, cond, expr)
`define CHBD_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif
`endif

// File: rtl/chbd_pkg.sv
// Shared constants and types for the complex halfband decimator.
// Used by the delay cell, the tap unit and the top level.
package chbd_pkg;
    localparam int SAMPLE_W  = 16;   // working sample width, 8 to 16
    localparam int FIELD_W   = 16;   // width of the sample ports
    localparam int COEF_W    = 16;
    localparam int QSHIFT    = 15;
    localparam int SUM_W     = SAMPLE_W + 1;
    localparam int PROD_W    = SUM_W + COEF_W;
    localparam int N_CELLS   = 7;    // each cell holds two of the 14 history samples
    localparam int N_TAPS    = 4;
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_OUTER  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_SECOND = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_THIRD  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_INNER  = CFG_IDX_W'(3);

    typedef logic signed [SAMPLE_W-1:0] t_samp;
    typedef logic signed [COEF_W-1:0]   t_coef;
    typedef logic signed [FIELD_W-1:0]  t_field;

    typedef struct packed {
        t_samp re;
        t_samp im;
    } t_cplx;

    // Load enables for the two registered stages of a tap.
    typedef struct packed {
        logic ld_sum;
        logic ld_prod;
    } t_pipe_ctl;
endpackage

// File: rtl/chbd_cell.sv
// One cell of the delay chain: holds two consecutive complex history samples.
// Depends on chbd_pkg.
module chbd_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_shift,
    input  chbd_pkg::t_cplx i_even,
    input  chbd_pkg::t_cplx i_odd,
    output chbd_pkg::t_cplx o_even,
    output chbd_pkg::t_cplx o_odd
);
    import chbd_pkg::*;

    t_cplx r_even;
    t_cplx r_odd;

    // The history moves by two samples per beat, so a cell takes both
    // samples of its upstream neighbor at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_even <= '0;
            r_odd  <= '0;
        end else if (i_shift) begin
            r_even <= i_even;
            r_odd  <= i_odd;
        end
    end

    assign o_even = r_even;
    assign o_odd  = r_odd;
endmodule

// File: rtl/chbd_tap.sv
// Symmetric tap unit: pre-add of two mirrored samples, registered multiply, Q15 scale.
// Depends on chbd_pkg.
module chbd_tap (
    input  logic                i_clk,
    input  chbd_pkg::t_pipe_ctl i_ctl,
    input  chbd_pkg::t_cplx     i_a,
    input  chbd_pkg::t_cplx     i_b,
    input  chbd_pkg::t_coef     i_coef,
    output chbd_pkg::t_cplx     o_term
);
    import chbd_pkg::*;

    logic signed [SUM_W-1:0]  r_sum_re;
    logic signed [SUM_W-1:0]  r_sum_im;
    logic signed [PROD_W-1:0] r_prod_re;
    logic signed [PROD_W-1:0] r_prod_im;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_sum) begin
            r_sum_re <= SUM_W'($signed(i_a.re)) + SUM_W'($signed(i_b.re));
            r_sum_im <= SUM_W'($signed(i_a.im)) + SUM_W'($signed(i_b.im));
        end
        if (i_ctl.ld_prod) begin
            r_prod_re <= PROD_W'(r_sum_re) * PROD_W'(i_coef);
            r_prod_im <= PROD_W'(r_sum_im) * PROD_W'(i_coef);
        end
    end

    // Arithmetic shift by the Q15 point, then keep the low sample bits.
    assign o_term.re = r_prod_re[QSHIFT+SAMPLE_W-1:QSHIFT];
    assign o_term.im = r_prod_im[QSHIFT+SAMPLE_W-1:QSHIFT];
endmodule

// File: rtl/complex_halfband_decimator_q15.sv
// Top level of the 15-tap complex halfband decimate-by-2 filter.
// Depends on chbd_pkg, chbd_cell, chbd_tap and the assertion macro header.
`include "complex_halfband_decimator_q15_macros.svh"
// Usage:
// Each input beat on the in channel carries two complex samples (first and
// second). The first sample completes the 15-sample window, one filtered
// output is formed, and then both samples enter the history. Every input beat
// yields exactly one output beat on the out channel.
// The four coefficients are written through the cfg channel, which is always
// ready; indexes beyond the last coefficient are ignored. Write them only
// while no beat is in flight.
// An accepted beat reaches output valid through pre-add, multiply, then
// scale-and-sum into the output register. Throughput is one beat per cycle
// while the receiver is ready, set by the seven-cell delay chain that shifts
// two samples per beat and the four tap units with one multiplier per component.
// When the receiver stalls, the three stages fill up and in_ready drops only
// once all of them hold a beat; no beat is lost or repeated.
// Synchronous reset clears the history to zero, the coefficients to zero and
// empties the pipeline.
module complex_halfband_decimator_q15 (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  chbd_pkg::t_field                   i_first_re,
    input  chbd_pkg::t_field                   i_first_im,
    input  chbd_pkg::t_field                   i_second_re,
    input  chbd_pkg::t_field                   i_second_im,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output chbd_pkg::t_field                   o_out_re,
    output chbd_pkg::t_field                   o_out_im,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [chbd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [chbd_pkg::COEF_W-1:0]        i_cfg_data
);
    import chbd_pkg::*;

    // Coefficient registers, indexed by tap position (outer first).
    t_coef r_coef [N_TAPS];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < N_TAPS; t++) begin
                r_coef[t] <= '0;
            end
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_COEF_OUTER:  r_coef[0] <= t_coef'(i_cfg_data);
                CFG_COEF_SECOND: r_coef[1] <= t_coef'(i_cfg_data);
                CFG_COEF_THIRD:  r_coef[2] <= t_coef'(i_cfg_data);
                CFG_COEF_INNER:  r_coef[3] <= t_coef'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Pipeline occupancy. Each stage moves when the next one is empty or moving.
    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic w_adv1;
    logic w_adv2;
    logic w_adv3;
    logic w_in_acc;

    assign w_adv3   = !r_v3 || i_out_ready;
    assign w_adv2   = !r_v2 || w_adv3;
    assign w_adv1   = !r_v1 || w_adv2;
    assign o_in_ready = w_adv1;
    assign w_in_acc = i_in_valid && w_adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_v1 <= i_in_valid;
            end
            if (w_adv2) begin
                r_v2 <= r_v1;
            end
            if (w_adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Incoming samples reduced to the working width.
    t_cplx w_first;
    t_cplx w_second;
    assign w_first.re  = t_samp'(i_first_re);
    assign w_first.im  = t_samp'(i_first_im);
    assign w_second.re = t_samp'(i_second_re);
    assign w_second.im = t_samp'(i_second_im);

    // Delay chain: cell j holds history samples 2j and 2j+1 (oldest in cell 0).
    t_cplx w_even [N_CELLS];
    t_cplx w_odd  [N_CELLS];

    genvar j;
    generate
        for (j = 0; j < N_CELLS; j++) begin : g_cell
            if (j == N_CELLS - 1) begin : g_last
                chbd_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (w_in_acc),
                    .i_even  (w_first),
                    .i_odd   (w_second),
                    .o_even  (w_even[j]),
                    .o_odd   (w_odd[j])
                );
            end else begin : g_mid
                chbd_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (w_in_acc),
                    .i_even  (w_even[j+1]),
                    .i_odd   (w_odd[j+1]),
                    .o_even  (w_even[j]),
                    .o_odd   (w_odd[j])
                );
            end
        end
    endgenerate

    // Tap units. The outer tap pairs the oldest sample with the incoming first
    // sample; the others pair mirrored even positions of the history.
    t_pipe_ctl w_ctl;
    assign w_ctl.ld_sum  = w_adv1;
    assign w_ctl.ld_prod = w_adv2;

    t_cplx w_term [N_TAPS];

    genvar t;
    generate
        for (t = 0; t < N_TAPS; t++) begin : g_tap
            if (t == 0) begin : g_outer
                chbd_tap u_tap (
                    .i_clk  (i_clk),
                    .i_ctl  (w_ctl),
                    .i_a    (w_even[0]),
                    .i_b    (w_first),
                    .i_coef (r_coef[t]),
                    .o_term (w_term[t])
                );
            end else begin : g_pair
                chbd_tap u_tap (
                    .i_clk  (i_clk),
                    .i_ctl  (w_ctl),
                    .i_a    (w_even[t]),
                    .i_b    (w_even[N_CELLS-t]),
                    .i_coef (r_coef[t]),
                    .o_term (w_term[t])
                );
            end
        end
    endgenerate

    // The center sample (history position 7) rides along the two tap stages.
    t_cplx r_ctr1;
    t_cplx r_ctr2;

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_ctr1 <= w_odd[N_TAPS-1];
        end
        if (w_adv2) begin
            r_ctr2 <= r_ctr1;
        end
    end

    // Final sum wraps at the working sample width.
    t_samp n_acc_re;
    t_samp n_acc_im;
    t_samp r_acc_re;
    t_samp r_acc_im;

    always_comb begin
        n_acc_re = r_ctr2.re;
        n_acc_im = r_ctr2.im;
        for (int k = 0; k < N_TAPS; k++) begin
            n_acc_re = n_acc_re + w_term[k].re;
            n_acc_im = n_acc_im + w_term[k].im;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv3) begin
            r_acc_re <= n_acc_re;
            r_acc_im <= n_acc_im;
        end
    end

    assign o_out_valid = r_v3;
    assign o_out_re    = t_field'(r_acc_re);
    assign o_out_im    = t_field'(r_acc_im);

    // A beat taken at the input always occupies the first stage next cycle.
    `CHBD_ASSERT_NEXT(a_in_to_stage1, i_clk, i_rst_n, w_in_acc, r_v1)
    // The input stalls only when every stage holds a beat.
    `CHBD_ASSERT_SAME(a_stall_full, i_clk, i_rst_n, !o_in_ready, r_v1 && r_v2 && r_v3)
    // A beat moving out of the product stage shows up at the output.
    `CHBD_ASSERT_NEXT(a_stage2_to_out, i_clk, i_rst_n, r_v2 && w_adv3, o_out_valid)
endmodule

// File: dv/complex_halfband_decimator_q15_tb.sv
// Self-checking testbench for the complex halfband decimate-by-2 filter.
// Depends on chbd_pkg and the RTL top level complex_halfband_decimator_q15.
`timescale 1ns / 100ps

module complex_halfband_decimator_q15_tb;
    import chbd_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int LATENCY       = 3;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int TIMEOUT_NS    = 10_000_000;
    localparam int HIST_LEN      = 14;
    localparam int CENTER_TAP    = 7;
    localparam int PHASE_BEATS   = 270;
    localparam int MAX_PRINTS    = 40;

    // Sample styles used by the random stimulus.
    typedef enum int {
        STYLE_FULL,
        STYLE_SMALL,
        STYLE_EXTREME
    } t_sample_style;

    typedef t_samp t_history [0:HIST_LEN-1];

    typedef struct {
        t_field re;
        t_field im;
    } t_out_pair;

    // Ports of the block.
    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    t_field           i_first_re;
    t_field           i_first_im;
    t_field           i_second_re;
    t_field           i_second_im;
    logic             o_out_valid;
    logic             i_out_ready;
    t_field           o_out_re;
    t_field           o_out_im;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [COEF_W-1:0]    i_cfg_data;

    // The testbench's own copy of the filter state: the 14 most recent samples
    // per component and the four coefficients as last written.
    t_history  hist_re;
    t_history  hist_im;
    t_coef     coef_model [0:N_TAPS-1];

    // Outputs predicted for accepted input beats, oldest first.
    t_out_pair pending_out [$];
    t_out_pair head_beat;

    int        mismatch_count;
    int        burst_left;

    complex_halfband_decimator_q15 uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_first_re  (i_first_re),
        .i_first_im  (i_first_im),
        .i_second_re (i_second_re),
        .i_second_im (i_second_im),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_re    (o_out_re),
        .o_out_im    (o_out_im),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2.0) i_clk = ~i_clk;

    // One filtered output for one component. The window is the history with
    // the newest first sample appended at position 14. Each outer pair is
    // pre-added at full precision, scaled by its coefficient, floored by the
    // Q15 shift and cut to the sample width; the four terms and the center
    // sample then add with wraparound at the sample width.
    function automatic t_field fir_output(input t_history line, input t_samp newest);
        t_samp                          win [0:HIST_LEN];
        logic signed [SAMPLE_W:0]        pair_sum;
        logic signed [SAMPLE_W+COEF_W:0] product;
        logic signed [SAMPLE_W+COEF_W:0] scaled;
        t_samp                          acc;
        t_field                         result;
        for (int i = 0; i < HIST_LEN; i++) begin
            win[i] = line[i];
        end
        win[HIST_LEN] = newest;
        acc = '0;
        for (int t = 0; t < N_TAPS; t++) begin
            pair_sum = win[2*t] + win[HIST_LEN - 2*t];
            product  = pair_sum * coef_model[t];
            scaled   = product >>> QSHIFT;
            acc      = acc + scaled[SAMPLE_W-1:0];
        end
        acc = acc + win[CENTER_TAP];
        // acc is signed, so this sign-extends into the 16-bit field.
        result = acc;
        return result;
    endfunction

    // Predicts the output of one accepted beat and advances the history by
    // the two samples the beat carries.
    function automatic t_out_pair predict_beat(input t_field fr, input t_field fi,
                                               input t_field sr, input t_field si);
        t_out_pair beat;
        t_samp     nfr;
        t_samp     nfi;
        t_samp     nsr;
        t_samp     nsi;
        // Only the low SAMPLE_W bits of each field take part.
        nfr = fr[SAMPLE_W-1:0];
        nfi = fi[SAMPLE_W-1:0];
        nsr = sr[SAMPLE_W-1:0];
        nsi = si[SAMPLE_W-1:0];
        beat.re = fir_output(hist_re, nfr);
        beat.im = fir_output(hist_im, nfi);
        for (int i = 0; i < HIST_LEN - 2; i++) begin
            hist_re[i] = hist_re[i+2];
            hist_im[i] = hist_im[i+2];
        end
        hist_re[HIST_LEN-2] = nfr;
        hist_im[HIST_LEN-2] = nfi;
        hist_re[HIST_LEN-1] = nsr;
        hist_im[HIST_LEN-1] = nsi;
        return beat;
    endfunction

    function automatic t_field random_sample(input t_sample_style style);
        t_field v;
        case (style)
            STYLE_SMALL: begin
                v = t_field'($urandom_range(0, 511)) - t_field'(256);
            end
            STYLE_EXTREME: begin
                case ($urandom_range(0, 3))
                    0:       v = 16'sh8000;
                    1:       v = 16'sh7fff;
                    2:       v = '0;
                    default: v = '1;
                endcase
            end
            default: begin
                v = t_field'($urandom);
            end
        endcase
        return v;
    endfunction

    // Prints one line per mismatch (up to a cap) and counts every one.
    task automatic report_mismatch(input string what, input t_field got, input t_field want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS) begin
            $display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    // Sends one input beat. The sender works in bursts: when a burst runs
    // out, valid drops for a random gap (sometimes none) before the next one
    // starts. Valid is only ever changed at a falling edge, once per edge,
    // and is held with a stable payload until the beat is taken.
    task automatic send_pair(input t_field fr, input t_field fi,
                             input t_field sr, input t_field si);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        burst_left--;
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_first_re  <= fr;
        i_first_im  <= fi;
        i_second_re <= sr;
        i_second_im <= si;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        pending_out.push_back(predict_beat(fr, fi, sr, si));
    endtask

    // Stops the sender and waits until every predicted output has come out,
    // then lets the pipeline settle.
    task automatic drain;
        int guard;
        guard = 0;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_out.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        if (pending_out.size() != 0) begin
            report_mismatch("output beats never delivered", '0, t_field'(pending_out.size()));
            pending_out.delete();
        end
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    // One register write on the configuration channel. The model copy is
    // updated only for indexes that name a coefficient; others are ignored.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [COEF_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        if (index < N_TAPS) begin
            coef_model[index[1:0]] = data;
        end
    endtask

    task automatic release_cfg;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Loads all four coefficients, only once the block has gone idle.
    task automatic load_coefs(input t_coef c_outer, input t_coef c_second,
                              input t_coef c_third, input t_coef c_inner);
        drain();
        write_reg(CFG_COEF_OUTER, c_outer);
        write_reg(CFG_COEF_SECOND, c_second);
        write_reg(CFG_COEF_THIRD, c_third);
        write_reg(CFG_COEF_INNER, c_inner);
        release_cfg();
    endtask

    // With coefficients still at their reset value of zero, each output is
    // just the center sample, which is zero until history reaches it.
    task automatic test_reset_state;
        send_pair(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
        send_pair(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
    endtask

    // An impulse in both samples of one beat, followed by zeros, walks the
    // two samples through every window position, outer pairs and center.
    task automatic test_impulse;
        load_coefs(16'sh7fff, 16'sh8000, 16'sh3039, -16'sh10e1);
        send_pair(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
        repeat (7) send_pair('0, '0, '0, '0);
    endtask

    // Full-scale samples against full-scale coefficients: the scaled terms
    // exceed the sample width and must wrap, with no saturation.
    task automatic test_overflow;
        load_coefs(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        repeat (3) send_pair(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        load_coefs(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        repeat (3) send_pair(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    endtask

    // Writes to indexes past the last coefficient must leave the
    // coefficients as they were.
    task automatic test_bad_index;
        drain();
        write_reg(CFG_IDX_W'(N_TAPS), 16'h5555);
        write_reg('1, 16'haaaa);
        write_reg(CFG_IDX_W'(128), 16'h8000);
        write_reg(CFG_IDX_W'($urandom_range(N_TAPS, 255)), 16'($urandom));
        release_cfg();
        repeat (4) begin
            send_pair(random_sample(STYLE_FULL), random_sample(STYLE_FULL),
                      random_sample(STYLE_FULL), random_sample(STYLE_FULL));
        end
    endtask

    // Random traffic in phases, each with its own coefficient set: a typical
    // halfband shape, all-positive and all-negative extremes, mixed extremes
    // and fully random sets. Samples mix full-range, small and extreme values.
    task automatic test_random;
        t_sample_style style;
        int            pick;
        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0:       load_coefs(16'sd150, -16'sd1300, 16'sd4800, 16'sd19500);
                1:       load_coefs(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
                2:       load_coefs(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
                3:       load_coefs(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
                default: load_coefs(t_coef'($urandom), t_coef'($urandom),
                                    t_coef'($urandom), t_coef'($urandom));
            endcase
            repeat (PHASE_BEATS) begin
                pick = $urandom_range(0, 9);
                if (pick < 6) begin
                    style = STYLE_FULL;
                end else if (pick < 8) begin
                    style = STYLE_SMALL;
                end else begin
                    style = STYLE_EXTREME;
                end
                send_pair(random_sample(style), random_sample(style),
                          random_sample(style), random_sample(style));
            end
        end
    endtask

    // Output checker: every beat taken on the out channel is compared with
    // the oldest prediction. Outputs are sampled at the rising edge, before
    // the block updates its registers for that edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_out.size() == 0) begin
                report_mismatch("output beat with none pending", o_out_re, '0);
            end else begin
                head_beat = pending_out.pop_front();
                if (o_out_re !== head_beat.re) begin
                    report_mismatch("out_re", o_out_re, head_beat.re);
                end
                if (o_out_im !== head_beat.im) begin
                    report_mismatch("out_im", o_out_im, head_beat.im);
                end
            end
        end
    end

    // Receiver back-pressure. Every so often a new stall mode is picked:
    // always ready, coin-flip, mostly ready, or long stalls with short
    // ready windows.
    initial begin
        int mode;
        int left;
        i_out_ready = 1'b0;
        mode = 0;
        left = 0;
        forever begin
            @(negedge i_clk);
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 200);
            end
            left--;
            case (mode)
                0:       i_out_ready <= 1'b1;
                1:       i_out_ready <= 1'($urandom_range(0, 1));
                2:       i_out_ready <= ($urandom_range(0, 7) != 0);
                default: i_out_ready <= ((left % 16) < 4);
            endcase
        end
    end

    // Hard limit on the run time.
    initial begin
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_first_re     = '0;
        i_first_im     = '0;
        i_second_re    = '0;
        i_second_im    = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        mismatch_count = 0;
        burst_left     = 0;
        for (int i = 0; i < HIST_LEN; i++) begin
            hist_re[i] = '0;
            hist_im[i] = '0;
        end
        for (int t = 0; t < N_TAPS; t++) begin
            coef_model[t] = '0;
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_impulse();
        test_overflow();
        test_bad_index();
        test_random();

        drain();
        repeat (LATENCY + 4) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
